[src/euclidean_tour_length_assert.svh]
// Assertion macros shared by the checker of the tour length block.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef EUCLIDEAN_TOUR_LENGTH_ASSERT_SVH
`define EUCLIDEAN_TOUR_LENGTH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ETL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ETL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/etl_pkg.sv]
`default_nettype none

package etl_pkg;

  // Field widths
  localparam int COORD_BITS = 16;
  localparam int TOTAL_BITS = 32;
  localparam int EDGE_BITS  = COORD_BITS + 1;

  // Square root datapath: radicand dx^2 + dy^2, root of EDGE_BITS bits
  localparam int ROOT_BITS  = COORD_BITS + 1;
  localparam int RAD_BITS   = 2 * COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS;

  // Width of the saturating total adder
  localparam int SUM_BITS   = ((TOTAL_BITS > EDGE_BITS) ? TOTAL_BITS : EDGE_BITS) + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EDGE_BITS-1:0]  edge_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [RAD_BITS-1:0]   rad_t;
  typedef logic [SQ_BITS-1:0]    sq_t;
  typedef logic [SUM_BITS-1:0]   sum_t;

  localparam total_t TOTAL_MAX = '1;

endpackage

`default_nettype wire

[src/etl_if.sv]
`default_nettype none

// City channel: one coordinate pair per transfer
interface etl_in_if import etl_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  logic   last_city;

  modport source (output valid, x_coord, y_coord, last_city, input ready);
  modport sink   (input valid, x_coord, y_coord, last_city, output ready);
endinterface

// Edge result channel
interface etl_out_if import etl_pkg::*; ();
  logic   valid;
  logic   ready;
  edge_t  edge_length;
  total_t running_total;
  logic   closing_edge;
  logic   tour_done;

  modport source (output valid, edge_length, running_total, closing_edge, tour_done,
                  input ready);
  modport sink   (input valid, edge_length, running_total, closing_edge, tour_done,
                  output ready);
endinterface

`default_nettype wire

[src/etl_sq.sv]
`default_nettype none

// Bit-serial sum of squares: dx*dx + dy*dy, one multiplier bit per cycle
module etl_sq import etl_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  coord_t dx,
  input  coord_t dy,
  output logic   done,
  output rad_t   sum_sq
);

  localparam int CNT_W = (COORD_BITS > 1) ? $clog2(COORD_BITS) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  sq_t              mcand_x_r, mcand_x_nxt, mcand_y_r, mcand_y_nxt;
  coord_t           mplr_x_r, mplr_x_nxt, mplr_y_r, mplr_y_nxt;
  sq_t              acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;

  // Shift-add step
  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    mcand_x_nxt = mcand_x_r;
    mcand_y_nxt = mcand_y_r;
    mplr_x_nxt  = mplr_x_r;
    mplr_y_nxt  = mplr_y_r;
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      mcand_x_nxt = SQ_BITS'(dx);
      mcand_y_nxt = SQ_BITS'(dy);
      mplr_x_nxt  = dx;
      mplr_y_nxt  = dy;
      acc_x_nxt   = '0;
      acc_y_nxt   = '0;
    end else if (busy_r) begin
      if (mplr_x_r[0]) acc_x_nxt = acc_x_r + mcand_x_r;
      if (mplr_y_r[0]) acc_y_nxt = acc_y_r + mcand_y_r;
      mcand_x_nxt = {mcand_x_r[SQ_BITS-2:0], 1'b0};
      mcand_y_nxt = {mcand_y_r[SQ_BITS-2:0], 1'b0};
      mplr_x_nxt  = mplr_x_r >> 1;
      mplr_y_nxt  = mplr_y_r >> 1;
      cnt_nxt     = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(COORD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r     <= cnt_nxt;
    mcand_x_r <= mcand_x_nxt;
    mcand_y_r <= mcand_y_nxt;
    mplr_x_r  <= mplr_x_nxt;
    mplr_y_r  <= mplr_y_nxt;
    acc_x_r   <= acc_x_nxt;
    acc_y_r   <= acc_y_nxt;
  end

  assign done   = done_r;
  assign sum_sq = RAD_BITS'(acc_x_r) + RAD_BITS'(acc_y_r);

endmodule

`default_nettype wire

[src/etl_sqrt.sv]
`default_nettype none

// Restoring square root, one root bit per cycle, rounded to nearest
module etl_sqrt import etl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  rad_t  radicand,
  output logic  done,
  output edge_t rounded
);

  localparam int CNT_W = $clog2(ROOT_BITS);
  localparam int REM_W = ROOT_BITS + 1;
  localparam int SH_W  = ROOT_BITS + 3;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [2*ROOT_BITS-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]   root_r, root_nxt;
  logic [SH_W-1:0]        rem_sh, trial;
  logic                   fits;

  // Bring down two radicand bits and try the next root bit
  assign rem_sh = {rem_r, rad_r[2*ROOT_BITS-1 -: 2]};
  assign trial  = SH_W'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = (2*ROOT_BITS)'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[2*ROOT_BITS-3:0], 2'b00};
      rem_nxt  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_nxt = {root_r[ROOT_BITS-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  // Remainder is n - r*r; round up when it exceeds r
  assign done    = done_r;
  assign rounded = EDGE_BITS'(root_r) + EDGE_BITS'(rem_r > REM_W'(root_r));

endmodule

`default_nettype wire

[src/euclidean_tour_length.sv]
`default_nettype none

// Euclidean tour length, rounded per edge to the nearest integer.
// in_ch takes the cities of a closed tour in visiting order, one x/y pair
// per transfer; last_city marks the final city. The first city of a tour
// gives no result unless it is also marked last. Every later city gives one
// result on out_ch: the edge from the previous city and the running total.
// A city marked last also gives the closing edge back to the first city,
// with closing_edge and tour_done set; the next city starts a new tour.
// Each edge goes through a bit-serial squarer and then a bit-serial
// square root. The closing edge of a city marked last starts once that
// city's own edge is emitted, with no input transfer between. in_ready
// is high only while no city is in flight. A finished result sits in the
// output register while the next city is taken; when out_ready stays low,
// the next edge waits after its square root until the register frees. The
// running total saturates at all ones. Reset (rst_n low, synchronous)
// closes any open tour and drops any result not yet transferred.
module euclidean_tour_length import etl_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  etl_in_if.sink         in_ch,
  etl_out_if.source      out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SQ,
    S_RT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   tour_open_r, tour_open_nxt;
  logic   phase_r, phase_nxt;      // 1 while working on the closing edge
  logic   last_r, last_nxt;
  coord_t cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  coord_t prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  coord_t first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  total_t total_r, total_nxt;
  logic   out_valid_r, out_valid_nxt;
  edge_t  out_edge_r, out_edge_nxt;
  total_t out_total_r, out_total_nxt;
  logic   out_close_r, out_close_nxt;

  coord_t a_x, a_y, b_x, b_y, dx, dy;
  logic   sq_start, sq_done, rt_done;
  rad_t   sum_sq;
  edge_t  edge_len;
  sum_t   sum_w;
  total_t total_sat;

  // Endpoints of the current edge
  assign a_x = phase_r ? cur_x_r : prev_x_r;
  assign a_y = phase_r ? cur_y_r : prev_y_r;
  assign b_x = phase_r ? first_x_r : cur_x_r;
  assign b_y = phase_r ? first_y_r : cur_y_r;
  assign dx  = (a_x >= b_x) ? a_x - b_x : b_x - a_x;
  assign dy  = (a_y >= b_y) ? a_y - b_y : b_y - a_y;

  etl_sq u_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .dx     (dx),
    .dy     (dy),
    .done   (sq_done),
    .sum_sq (sum_sq)
  );

  etl_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_done),
    .radicand (sum_sq),
    .done     (rt_done),
    .rounded  (edge_len)
  );

  // Saturating total
  assign sum_w     = SUM_BITS'(total_r) + SUM_BITS'(edge_len);
  assign total_sat = (sum_w > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_BITS'(sum_w);

  // Control sequence
  always_comb begin
    state_nxt     = state_r;
    tour_open_nxt = tour_open_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_edge_nxt  = out_edge_r;
    out_total_nxt = out_total_r;
    out_close_nxt = out_close_r;
    sq_start      = 1'b0;

    if (out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_x_nxt = in_ch.x_coord;
          cur_y_nxt = in_ch.y_coord;
          last_nxt  = in_ch.last_city;
          if (!tour_open_r) begin
            // first city of a tour
            first_x_nxt   = in_ch.x_coord;
            first_y_nxt   = in_ch.y_coord;
            prev_x_nxt    = in_ch.x_coord;
            prev_y_nxt    = in_ch.y_coord;
            total_nxt     = '0;
            tour_open_nxt = 1'b1;
            if (in_ch.last_city) begin
              phase_nxt = 1'b1;
              state_nxt = S_LOAD;
            end
          end else begin
            phase_nxt = 1'b0;
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        sq_start  = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (sq_done) state_nxt = S_RT;
      end
      S_RT: begin
        if (rt_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_edge_nxt  = edge_len;
          out_total_nxt = total_sat;
          out_close_nxt = phase_r;
          total_nxt     = total_sat;
          if (!phase_r) begin
            prev_x_nxt = cur_x_r;
            prev_y_nxt = cur_y_r;
            if (last_r) begin
              phase_nxt = 1'b1;
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            tour_open_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tour_open_r <= 1'b0;
      phase_r     <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tour_open_r <= tour_open_nxt;
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r      <= last_nxt;
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    prev_x_r    <= prev_x_nxt;
    prev_y_r    <= prev_y_nxt;
    first_x_r   <= first_x_nxt;
    first_y_r   <= first_y_nxt;
    out_edge_r  <= out_edge_nxt;
    out_total_r <= out_total_nxt;
    out_close_r <= out_close_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.edge_length   = out_edge_r;
  assign out_ch.running_total = out_total_r;
  assign out_ch.closing_edge  = out_close_r;
  assign out_ch.tour_done     = out_close_r;

endmodule

`default_nettype wire

[src/etl_chk.sv]
`default_nettype none

`include "euclidean_tour_length_assert.svh"

// Port-level checks on the tour length block
module etl_chk import etl_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_valid,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire edge_t  out_edge_length,
  input wire total_t out_running_total,
  input wire logic   out_closing_edge,
  input wire logic   out_tour_done
);

  // A stalled result holds
  `ETL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_edge_length) && $stable(out_running_total) && $stable(out_closing_edge), "stalled result changed")

  // The closing edge is always the end of the tour
  `ETL_ASSERT_NOW(a_done_close, out_valid, out_tour_done == out_closing_edge, "tour_done differs from closing_edge")

  // The total includes the edge just reported
  `ETL_ASSERT_NOW(a_total_ge, out_valid, SUM_BITS'(out_running_total) >= SUM_BITS'(out_edge_length), "running total below edge")

  // An edge passes through the squarer and the square root: no new result right after a city transfer
  `ETL_ASSERT_NEXT(a_no_quick_result, in_valid && in_ready, !$rose(out_valid), "result right after a city transfer")

endmodule

bind euclidean_tour_length etl_chk u_etl_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_edge_length   (out_ch.edge_length),
  .out_running_total (out_ch.running_total),
  .out_closing_edge  (out_ch.closing_edge),
  .out_tour_done     (out_ch.tour_done)
);

`default_nettype wire
